// File: src/bfba_pkg.sv
// shared types, constants and helpers of the bitmap free block allocator
`timescale 1ns / 1ps

package bfba_pkg;

  localparam int FIELD_W         = 12;    // width of block numbers on the ports
  localparam int WIDE_W          = 17;    // holds any block count up to 65536
  localparam int WORD_W          = 32;    // map bits per memory word
  localparam int BIT_W           = 5;     // bit index inside a word
  localparam int DEF_BLOCK_COUNT = 4096;
  localparam int RESERVED_BLOCKS = 10;    // used after formatting
  localparam int DEF_FIRST_BLOCK = 10;

  // first map word after reset: reserved blocks used, the rest free
  localparam logic [WORD_W-1:0] INIT_WORD0 =
    ~WORD_W'((64'd1 << RESERVED_BLOCKS) - 64'd1);
  localparam logic [WORD_W-1:0] INIT_WORD = {WORD_W{1'b1}};

  typedef enum logic [1:0] {
    CMD_FIND      = 2'd0,
    CMD_MARK_USED = 2'd1,
    CMD_MARK_FREE = 2'd2,
    CMD_ALLOC     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] bit_idx;
  } search_hit_t;

  // index of the lowest set bit, zero when none is set
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: src/bfba_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module bfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/bfba_word_search.sv
// masks one map word to the searchable range and finds its lowest free bit
`timescale 1ns / 1ps

module bfba_word_search #(
  parameter int BLOCK_COUNT = bfba_pkg::DEF_BLOCK_COUNT
) (
  input  logic [bfba_pkg::WORD_W-1:0] word,
  input  logic                        at_start,
  input  logic [bfba_pkg::BIT_W-1:0]  start_bit,
  input  logic                        at_last,
  output bfba_pkg::search_hit_t       hit
);

  import bfba_pkg::*;

  localparam int WORD_COUNT = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int LAST_BITS  = BLOCK_COUNT - WORD_W * (WORD_COUNT - 1);
  localparam logic [WORD_W-1:0] LAST_MASK = WORD_W'((64'd1 << LAST_BITS) - 64'd1);

  logic [WORD_W-1:0] start_mask;
  logic [WORD_W-1:0] last_mask;
  logic [WORD_W-1:0] cand;

  always_comb begin
    start_mask  = at_start ? ({WORD_W{1'b1}} << start_bit) : {WORD_W{1'b1}};
    last_mask   = at_last ? LAST_MASK : {WORD_W{1'b1}};
    cand        = word & start_mask & last_mask;
    hit.hit     = |cand;
    hit.bit_idx = lowest_set(cand);
  end

endmodule

// File: src/bitmap_free_block_allocator.sv
// top level: command sequencer, free map memory and result register
`timescale 1ns / 1ps
//
// channel   direction  signals                          role
// in        input      in_valid/in_ready, command,      one command per transfer
//                      block_number
// out       output     out_valid/out_ready,             one result per command
//                      result_block, found
// cfg       input      cfg_write_en, cfg_write_data     first searchable block
//
// mark used / mark free: accept, read-modify-write, result
// find / allocate: accept, then scan from the start word until a hit or the end,
//   at most BLOCK_COUNT/32 words (128 for 4096 blocks); one read port, 32 bits a cycle
// reset: a clearing pass writes every map word (128 for 4096 blocks),
//   in_ready stays low during it
// a stalled result waits in the output register; the sequencer holds in its
//   done state until that register frees, then takes the next command

module bitmap_free_block_allocator #(
  parameter int BLOCK_COUNT = bfba_pkg::DEF_BLOCK_COUNT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [bfba_pkg::FIELD_W-1:0] block_number,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bfba_pkg::FIELD_W-1:0] result_block,
  output logic                         found,
  input  logic                         cfg_write_en,
  input  logic [bfba_pkg::FIELD_W-1:0] cfg_write_data
);

  import bfba_pkg::*;

  localparam int WORD_COUNT = (BLOCK_COUNT + WORD_W - 1) / WORD_W;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam logic [AW-1:0]     LAST_WORD  = AW'(WORD_COUNT - 1);
  localparam logic [WIDE_W-1:0] BLOCK_WIDE = WIDE_W'(BLOCK_COUNT);

  // sequencer state
  state_t state, state_next;

  // command being worked on
  cmd_t               cmd_q;
  logic [FIELD_W-1:0] blk_q;
  logic [AW-1:0]      scan_addr;
  logic [AW-1:0]      clr_addr;

  // result waiting to go into the output register
  logic [FIELD_W-1:0] res_block;
  logic               res_found;

  // config register
  logic [FIELD_W-1:0] first_searchable_block;

  // memory ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  search_hit_t hit;

  // decoded input and config
  cmd_t              in_cmd;
  logic              accept;
  logic              in_is_mark;
  logic [WIDE_W-1:0] blk_wide;
  logic              blk_in_range;
  logic [WIDE_W-1:0] first_wide;
  logic              first_in_range;
  logic [AW-1:0]     first_word;
  logic [AW-1:0]     blk_word;
  logic [WIDE_W-1:0] q_wide;
  logic [AW-1:0]     q_word;
  logic [WORD_W-1:0] mark_bit;
  logic [WORD_W-1:0] hit_bit;
  logic [WIDE_W-1:0] hit_wide;
  logic              scan_end;
  logic              out_free;

  assign in_ready       = (state == ST_IDLE);
  assign accept         = in_valid && in_ready;
  assign in_cmd         = cmd_t'(command);
  assign in_is_mark     = (in_cmd == CMD_MARK_USED) || (in_cmd == CMD_MARK_FREE);
  assign blk_wide       = WIDE_W'(block_number);
  assign blk_in_range   = blk_wide < BLOCK_WIDE;
  assign blk_word       = blk_wide[AW+BIT_W-1:BIT_W];
  assign first_wide     = WIDE_W'(first_searchable_block);
  assign first_in_range = first_wide < BLOCK_WIDE;
  assign first_word     = first_wide[AW+BIT_W-1:BIT_W];
  assign q_wide         = WIDE_W'(blk_q);
  assign q_word         = q_wide[AW+BIT_W-1:BIT_W];
  assign mark_bit       = {{(WORD_W-1){1'b0}}, 1'b1} << blk_q[BIT_W-1:0];
  assign hit_bit        = {{(WORD_W-1){1'b0}}, 1'b1} << hit.bit_idx;
  assign hit_wide       = WIDE_W'({scan_addr, hit.bit_idx});
  assign scan_end       = (scan_addr == LAST_WORD);
  assign out_free       = !out_valid || out_ready;

  // free map, bit j of word w is block 32*w+j, set means free
  bfba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // masks the word under scan to the start block and the end of the map
  bfba_word_search #(
    .BLOCK_COUNT (BLOCK_COUNT)
  ) u_search (
    .word      (ram_rdata),
    .at_start  (scan_addr == first_word),
    .start_bit (first_searchable_block[BIT_W-1:0]),
    .at_last   (scan_end),
    .hit       (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_WORD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_is_mark) begin
            state_next = blk_in_range ? ST_MARK : ST_DONE;
          end else begin
            state_next = first_in_range ? ST_SCAN : ST_DONE;
          end
        end
      end
      ST_MARK: begin
        state_next = ST_DONE;
      end
      ST_SCAN: begin
        if (hit.hit || scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // memory control; mark and allocate writes pass through the done state before the next
  // read, and a scan reads the word after the one it writes, so no forwarding is needed
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_addr;
    ram_wdata = (clr_addr == '0) ? INIT_WORD0 : INIT_WORD;
    ram_raddr = first_word;
    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        // marks fetch the word of their block, searches the start word
        ram_raddr = in_is_mark ? blk_word : first_word;
      end
      ST_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = q_word;
        ram_wdata = (cmd_q == CMD_MARK_FREE) ? (ram_rdata | mark_bit)
                                             : (ram_rdata & ~mark_bit);
      end
      ST_SCAN: begin
        // next word is fetched while this one is searched
        ram_raddr = scan_addr + AW'(1);
        ram_we    = hit.hit && (cmd_q == CMD_ALLOC);
        ram_waddr = scan_addr;
        ram_wdata = ram_rdata & ~hit_bit;
      end
      ST_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_searchable_block <= FIELD_W'(DEF_FIRST_BLOCK);
    end else if (cfg_write_en) begin
      first_searchable_block <= cfg_write_data;
    end
  end

  // command and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q     <= in_cmd;
      blk_q     <= block_number;
      scan_addr <= first_word;
    end else if (state == ST_SCAN) begin
      scan_addr <= scan_addr + AW'(1);
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      // out-of-range mark echoes its block, early miss answers zero
      res_block <= in_is_mark ? block_number : '0;
      res_found <= 1'b0;
    end else if (state == ST_MARK) begin
      res_block <= blk_q;
      res_found <= 1'b1;
    end else if (state == ST_SCAN && hit.hit) begin
      res_block <= hit_wide[FIELD_W-1:0];
      res_found <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      result_block <= res_block;
      found        <= res_found;
    end
  end

  // map is never written while waiting for a command or a free output slot
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE || state == ST_DONE) |-> !ram_we)
    else $error("map written outside a working state");

  // an accepted command always leaves the idle state
  assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted command did not start");

  // an allocate hit writes back the scanned word
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && hit.hit && cmd_q == CMD_ALLOC) |->
      (ram_we && ram_waddr == scan_addr))
    else $error("allocate hit not written back");

  // a result waiting on a stalled output holds the sequencer
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && !out_ready) |=> state == ST_DONE)
    else $error("result dropped under stall");

  // scan never runs past the last map word
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> scan_addr <= LAST_WORD)
    else $error("scan beyond end of map");

endmodule

// File: tb/sv/alloc_check_pkg.sv
// free map tracker that predicts and checks every allocator answer
`timescale 1ns / 1ps

package alloc_check_pkg;
  import bfba_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] block;
    logic               hit;
  } alloc_answer_t;

  class alloc_tracker;
    bit                 free_bits [DEF_BLOCK_COUNT];
    logic [FIELD_W-1:0] search_start;
    alloc_answer_t      answers_due [$];
    int unsigned        cmd_count [4];
    int unsigned        empty_searches;
    int unsigned        zero_hits;
    int unsigned        checked;
    int unsigned        errors;

    // formatted map: reserved blocks used, everything else free
    function new();
      for (int b = 0; b < DEF_BLOCK_COUNT; b++) begin
        free_bits[b] = (b >= RESERVED_BLOCKS);
      end
      search_start = FIELD_W'(DEF_FIRST_BLOCK);
    endfunction

    function void set_start(logic [FIELD_W-1:0] value);
      search_start = value;
    endfunction

    function int pending();
      return answers_due.size();
    endfunction

    // accepted command: update the map copy and queue the answer it earns
    function void take_command(cmd_t cmd, logic [FIELD_W-1:0] blk);
      alloc_answer_t due;
      int b;
      due = '0;
      cmd_count[cmd]++;
      if (cmd == CMD_MARK_USED || cmd == CMD_MARK_FREE) begin
        due.block = blk;
        if (int'(blk) < DEF_BLOCK_COUNT) begin
          free_bits[blk] = (cmd == CMD_MARK_FREE);
          due.hit = 1'b1;
        end
      end else begin
        // lowest free block at or above the start, a miss answers block 0
        b = int'(search_start);
        while (b < DEF_BLOCK_COUNT && !free_bits[b]) begin
          b++;
        end
        if (b < DEF_BLOCK_COUNT) begin
          due.block = FIELD_W'(b);
          due.hit = 1'b1;
          if (b == 0) begin
            zero_hits++;
          end
          if (cmd == CMD_ALLOC) begin
            free_bits[b] = 1'b0;
          end
        end else begin
          empty_searches++;
        end
      end
      answers_due.push_back(due);
    endfunction

    function void flag(string what);
      errors++;
      $error("%s", what);
    endfunction

    // result transfer: compare against the oldest queued answer
    function void check_answer(logic [FIELD_W-1:0] blk, logic hit);
      alloc_answer_t due;
      checked++;
      if (answers_due.size() == 0) begin
        flag($sformatf("result_block %0d found %0b arrived with no command outstanding",
                       blk, hit));
        return;
      end
      due = answers_due.pop_front();
      if (blk !== due.block) begin
        flag($sformatf("result_block: expected %0d, actual %0d", due.block, blk));
      end
      if (hit !== due.hit) begin
        flag($sformatf("found: expected %0b, actual %0b", due.hit, hit));
      end
    endfunction
  endclass

endpackage

// File: tb/sv/testbench.sv
// top of the allocator testbench: clock, reset, command and result drivers, run control
`timescale 1ns / 1ps

module testbench;
  import bfba_pkg::*;
  import alloc_check_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int LONG_HOLD     = 400;   // receiver hold-off that backs the block up
  localparam int SETTLE_CYCLES = 300;   // longer than a full 128-word scan
  localparam int SEGMENTS      = 12;
  localparam int SEG_ITEMS     = 85;

  logic               clk            = 1'b0;
  logic               rst            = 1'b1;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic [1:0]         command        = CMD_FIND;
  logic [FIELD_W-1:0] block_number   = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [FIELD_W-1:0] result_block;
  logic               found;
  logic               cfg_write_en   = 1'b0;
  logic [FIELD_W-1:0] cfg_write_data = '0;

  // idling knobs, percent of cycles
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // long hold-off request, picked up and counted down by the receiver
  bit long_hold_req = 1'b0;
  int hold_left     = 0;

  int cycle_count  = 0;
  int start_writes = 0;

  alloc_tracker tracker = new();

  always #5 clk = ~clk;

  bitmap_free_block_allocator #(
    .BLOCK_COUNT(DEF_BLOCK_COUNT)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .block_number  (block_number),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_block  (result_block),
    .found         (found),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data)
  );

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("bitmap_free_block_allocator: mismatch");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        tracker.check_answer(result_block, found);
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // one command transfer; valid stays up from the previous item when no gap is drawn
  task automatic send_command(input cmd_t cmd, input logic [FIELD_W-1:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    command      <= cmd;
    block_number <= blk;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    tracker.take_command(cmd, blk);
  endtask

  // stop offering and wait until every queued answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // only called with the block idle
  task automatic write_start(input logic [FIELD_W-1:0] value);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    tracker.set_start(value);
    start_writes++;
  endtask

  // random command, block numbers mostly just above the start so marks
  // and allocations keep reshaping the region that searches land in
  task automatic send_random(input logic [FIELD_W-1:0] start);
    int pick;
    int near;
    cmd_t cmd;
    logic [FIELD_W-1:0] blk;
    pick = $urandom_range(99);
    if (pick < 25) begin
      cmd = CMD_FIND;
    end else if (pick < 60) begin
      cmd = CMD_ALLOC;
    end else if (pick < 75) begin
      cmd = CMD_MARK_USED;
    end else begin
      cmd = CMD_MARK_FREE;
    end
    near = int'(start) + int'($urandom_range(95));
    if ($urandom_range(9) < 7 && near < DEF_BLOCK_COUNT) begin
      blk = FIELD_W'(near);
    end else begin
      blk = FIELD_W'($urandom);
    end
    send_command(cmd, blk);
  endtask

  initial begin
    logic [FIELD_W-1:0] seg_start;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset start of 10: first search lands just past the reserved blocks,
    // block_number of find and allocate is don't-care
    send_command(CMD_FIND, 12'h000);
    send_command(CMD_ALLOC, 12'hfff);
    send_command(CMD_FIND, 12'haaa);
    send_command(CMD_MARK_FREE, 12'd10);
    send_command(CMD_ALLOC, 12'h555);
    // top block, repeated marks on block 0, then marks on two middle blocks
    send_command(CMD_MARK_USED, 12'hfff);
    send_command(CMD_MARK_FREE, 12'hfff);
    send_command(CMD_MARK_USED, 12'h000);
    send_command(CMD_MARK_USED, 12'h000);
    send_command(CMD_MARK_FREE, 12'h000);
    send_command(CMD_MARK_FREE, 12'h000);
    send_command(CMD_MARK_USED, 12'h555);
    send_command(CMD_MARK_FREE, 12'haaa);
    drain();

    // start 0 with block 0 free: a hit on block 0 with found set
    write_start(12'h000);
    send_command(CMD_FIND, 12'h000);
    send_command(CMD_ALLOC, 12'h000);
    send_command(CMD_FIND, 12'hfff);
    drain();

    // start at the last block: hits until it is allocated, misses, then freed and hit again
    write_start(12'hfff);
    send_command(CMD_FIND, 12'h000);
    send_command(CMD_ALLOC, 12'h000);
    send_command(CMD_FIND, 12'h000);
    send_command(CMD_ALLOC, 12'hfff);
    send_command(CMD_MARK_FREE, 12'hfff);
    send_command(CMD_ALLOC, 12'h000);
    send_command(CMD_MARK_FREE, 12'hfff);
    drain();

    // random segments, three per idling mode, a fresh start for each
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 3)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 21;
          recv_stall_pct = 21;
        end
      endcase
      if (seg == 0 || seg == 10) begin
        seg_start = '0;
      end else if (seg == 4 || seg == 7) begin
        seg_start = '1;
      end else if ($urandom_range(1) == 0) begin
        seg_start = FIELD_W'($urandom_range(255));
      end else begin
        seg_start = FIELD_W'($urandom);
      end
      write_start(seg_start);
      // back the block up once: the receiver holds off while commands keep coming
      if (seg == 1) begin
        long_hold_req = 1'b1;
      end
      for (int n = 0; n < SEG_ITEMS; n++) begin
        send_random(seg_start);
      end
      drain();
    end

    // nothing should trickle out after the last answer
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d finds, %0d allocates, %0d marks used, %0d marks freed",
             tracker.cmd_count[CMD_FIND], tracker.cmd_count[CMD_ALLOC],
             tracker.cmd_count[CMD_MARK_USED], tracker.cmd_count[CMD_MARK_FREE]);
    $display("%0d searches came up empty, %0d hit block 0, %0d start settings, %0d results seen",
             tracker.empty_searches, tracker.zero_hits, start_writes, tracker.checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("bitmap_free_block_allocator: match");
    end else begin
      $display("bitmap_free_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
